>>> src/ida_pkg.sv
// ----------------------------------------------------------------------------
// ida_pkg
// Shared types and constants for the integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package ida_pkg;

	localparam int VALUE_BITS     = 64;
	localparam int CHAR_BITS      = 6;
	localparam int VALUE_WIDTH_DEF = 64;

	localparam logic [CHAR_BITS-1:0] MINUS_CHAR = 6'd45;
	localparam logic [CHAR_BITS-1:0] ZERO_CHAR  = 6'd48;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SCAN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic                  func;
	} req_t;

	typedef struct packed {
		logic [CHAR_BITS-1:0] character;
		logic                 last;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic step;
		logic emit_sign;
		logic emit_digit;
		logic last;
	} ctl_t;

endpackage

>>> src/ida_dabble.sv
// ----------------------------------------------------------------------------
// ida_dabble
// Shift-add-3 binary to BCD unit; one binary bit is consumed per step.
// ----------------------------------------------------------------------------
module ida_dabble #(
	parameter int VALUE_WIDTH = ida_pkg::VALUE_WIDTH_DEF,
	parameter int NDIG        = (VALUE_WIDTH * 1233) / 4096 + 1,
	parameter int IW          = $clog2(NDIG)
) (
	input  logic                   clk,
	input  ida_pkg::ctl_t          ctl,
	input  logic [VALUE_WIDTH-1:0] mag,
	input  logic [IW-1:0]          idx,
	output logic [3:0]             digit
);
	import ida_pkg::*;

	logic [VALUE_WIDTH-1:0] bin_q;
	logic [NDIG*4-1:0]      bcd_q;
	logic [NDIG*4-1:0]      adj;

	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			bin_q <= mag;
			bcd_q <= '0;
		end else if (ctl.step) begin
			bin_q <= {bin_q[VALUE_WIDTH-2:0], 1'b0};
			bcd_q <= {adj[NDIG*4-2:0], bin_q[VALUE_WIDTH-1]};
		end
	end

	assign digit = bcd_q[idx*4 +: 4];

endmodule

>>> src/ida_seq.sv
// ----------------------------------------------------------------------------
// ida_seq
// Sequencer: conversion count, leading zero scan and character emission.
// ----------------------------------------------------------------------------
module ida_seq #(
	parameter int VALUE_WIDTH = ida_pkg::VALUE_WIDTH_DEF,
	parameter int NDIG        = (VALUE_WIDTH * 1233) / 4096 + 1,
	parameter int IW          = $clog2(NDIG)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          neg,
	input  logic [3:0]    digit,
	output logic          busy,
	output logic [IW-1:0] idx,
	output ida_pkg::ctl_t ctl
);
	import ida_pkg::*;

	localparam int CW = $clog2(VALUE_WIDTH + 1);

	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] idx_q;
	logic          neg_q;
	logic          found;
	logic          idx_zero;

	assign idx_zero = (idx_q == '0);
	assign found    = (digit != 4'd0) || idx_zero;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_CONV;
			end
			ST_CONV: begin
				if (cnt_q == CW'(1)) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (found) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (idx_zero) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl  = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				ctl.load = start;
			end
			ST_CONV: begin
				ctl.step = 1'b1;
			end
			ST_SCAN: begin
				ctl.emit_sign = found & neg_q;
			end
			ST_EMIT: begin
				ctl.emit_digit = 1'b1;
				ctl.last       = idx_zero;
			end
			default: busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
			neg_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load) begin
				cnt_q <= CW'(VALUE_WIDTH);
				idx_q <= IW'(NDIG - 1);
				neg_q <= neg;
			end else begin
				if (ctl.step) cnt_q <= cnt_q - CW'(1);
				if ((state_q == ST_SCAN && !found) || (state_q == ST_EMIT && !idx_zero)) begin
					idx_q <= idx_q - IW'(1);
				end
			end
		end
	end

	assign idx = idx_q;

endmodule

>>> src/integer_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii_top
// Converts one integer, signed or unsigned, to its decimal ASCII text.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy low. The text leaves one
// character per cycle on rsp, marked by strobe, most significant first, a
// leading '-' for negative signed values, last set on the final character.
// There is no back-pressure: the receiver must take every strobed cycle.
// While a request keeps busy high, the BCD unit takes one shift-add-3 step
// per input bit, then the sequencer scans past the leading zero digits and
// emits the remaining digits of the NDIG positions (NDIG = 20 at 64 bits).
// ----------------------------------------------------------------------------
module integer_to_decimal_ascii_top #(
	parameter int VALUE_WIDTH = ida_pkg::VALUE_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ida_pkg::req_t req,
	output logic          strobe,
	output ida_pkg::rsp_t rsp
);
	import ida_pkg::*;

	localparam int NDIG = (VALUE_WIDTH * 1233) / 4096 + 1;
	localparam int IW   = $clog2(NDIG);

	logic [VALUE_WIDTH-1:0] raw;
	logic [VALUE_WIDTH-1:0] mag;
	logic                   neg;
	logic [IW-1:0]          idx;
	logic [3:0]             digit;
	ctl_t                   ctl;
	rsp_t                   rsp_q;
	logic                   strobe_q;

	assign raw = req.value[VALUE_WIDTH-1:0];
	assign neg = req.func & raw[VALUE_WIDTH-1];
	assign mag = neg ? (~raw + VALUE_WIDTH'(1)) : raw;

	ida_seq #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.NDIG        (NDIG),
		.IW          (IW)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.neg    (neg),
		.digit  (digit),
		.busy   (busy),
		.idx    (idx),
		.ctl    (ctl)
	);

	ida_dabble #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.NDIG        (NDIG),
		.IW          (IW)
	) u_dabble (
		.clk   (clk),
		.ctl   (ctl),
		.mag   (mag),
		.idx   (idx),
		.digit (digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= ctl.emit_sign | ctl.emit_digit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit_sign) begin
			rsp_q.character <= MINUS_CHAR;
			rsp_q.last      <= 1'b0;
		end else if (ctl.emit_digit) begin
			rsp_q.character <= ZERO_CHAR + {2'b00, digit};
			rsp_q.last      <= ctl.last;
		end
	end

	assign strobe = strobe_q;
	assign rsp    = rsp_q;

endmodule
